/* hw/rtl/hbd_pkg.sv */
package hbd_pkg;

    // defaults for the top-level parameters
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 20;

    // record length register
    localparam int CFG_BITS = 20;
    localparam logic [CFG_BITS-1:0] RECORD_LENGTH_RESET = 20'd1024;

    // filter geometry
    localparam int TAP_PAIRS   = 5;
    localparam int DEPTH       = 4 * TAP_PAIRS - 1;
    localparam int LAG         = 2 * TAP_PAIRS - 1;
    localparam int IDX_BITS    = $clog2(DEPTH);
    localparam int OFF_BITS    = $clog2(DEPTH + 2 * LAG) + 1;
    localparam int MAX_RESULTS = 6;
    localparam int PEND_BITS   = $clog2(MAX_RESULTS + 1);

    // q1.15 coefficients with the 1/2.029 gain folded in
    localparam int COEF_BITS  = 16;
    localparam int FRAC_BITS  = 15;
    localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);
    localparam logic signed [COEF_BITS-1:0] CENTRE_COEF = 16'sd16150;
    localparam logic signed [COEF_BITS-1:0] PAIR_COEF [TAP_PAIRS] = '{
        16'sd10215, -16'sd3232, 16'sd1742, -16'sd1048, 16'sd634
    };

    typedef logic [PEND_BITS-1:0] pend_t;

endpackage

/* hw/rtl/half_band_decimator_top.sv */
// Half-band decimator by two. Each input item carries one signed sample of a record whose
// length is set by the record length register (cfg_we/cfg_wdata, write only while idle).
// A record of L samples gives floor(L/2) results; result i is centred on sample 2i and is
// an 11-tap symmetric half-band FIR (rounded half up, saturated) except for the first five
// and last five results, which pass sample 2i through. Result i leaves once sample 2i+9
// has been taken; on the record's last sample all pending results come out as a burst of
// at most six, the final one flagged by record_end. Rate: one item per clock while each
// item causes at most one result and the output side keeps up; an item that causes a
// burst of results holds in_ready low until its last result issues, since the single tap
// selection stage issues one result per cycle while the stages after it can take it. From
// input acceptance a result passes the result descriptor, tap select and pre-add, constant
// multiply and output registers, with the tap sum, rounding and saturation ahead of the last.
module half_band_decimator_top #(
    parameter int SAMPLE_BITS = hbd_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = hbd_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hbd_pkg::CFG_BITS-1:0]      cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [SAMPLE_BITS-1:0]     out_sample,
    output logic                              record_end
);

    localparam int DEPTH     = hbd_pkg::DEPTH;
    localparam int TAP_PAIRS = hbd_pkg::TAP_PAIRS;
    localparam int LAG       = hbd_pkg::LAG;
    localparam int IDX_BITS  = hbd_pkg::IDX_BITS;
    localparam int OFF_BITS  = hbd_pkg::OFF_BITS;
    localparam int FRAC_BITS = hbd_pkg::FRAC_BITS;

    // widths of the count compares and of the signed centre offset
    localparam int CW2 = COUNT_BITS + 2;
    localparam int CW  = COUNT_BITS + 3;
    localparam int C_LO = -LAG;
    localparam int C_HI = DEPTH - 1 + LAG;

    // datapath widths
    localparam int PSUM_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = PSUM_BITS + hbd_pkg::COEF_BITS;
    localparam int ACC_BITS  = PROD_BITS + 3;
    localparam int Q_BITS    = ACC_BITS - FRAC_BITS;

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // clamp a tap offset to the ends of the delay line
    function automatic logic [IDX_BITS-1:0] tap_index(input logic signed [OFF_BITS-1:0] off);
        logic [IDX_BITS-1:0] idx;
        if (off < OFF_BITS'(0))
            idx = '0;
        else if (off > OFF_BITS'(DEPTH - 1))
            idx = IDX_BITS'(DEPTH - 1);
        else
            idx = off[IDX_BITS-1:0];
        return idx;
    endfunction

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    logic [hbd_pkg::CFG_BITS-1:0]   record_length_reg;
    logic signed [SAMPLE_BITS-1:0]  dl_reg [DEPTH];
    logic [COUNT_BITS-1:0]          in_cnt_reg, in_cnt_next;
    logic [COUNT_BITS-1:0]          out_cnt_reg, out_cnt_next;

    // result descriptor: results still to issue for the last item taken
    hbd_pkg::pend_t                 pend_reg, pend_next;
    logic [COUNT_BITS-1:0]          idx_reg, idx_next;
    logic [COUNT_BITS-1:0]          n_reg, n_next;
    logic [COUNT_BITS-1:0]          total_reg, total_next;
    logic                           last_reg, last_next;

    // tap select stage
    logic                           a_valid_reg, a_valid_next;
    logic signed [SAMPLE_BITS-1:0]  a_centre_reg, a_centre_next;
    logic signed [PSUM_BITS-1:0]    a_psum_reg [TAP_PAIRS];
    logic signed [PSUM_BITS-1:0]    a_psum_next [TAP_PAIRS];
    logic                           a_pass_reg, a_pass_next;
    logic                           a_end_reg, a_end_next;

    // product stage
    logic                           b_valid_reg, b_valid_next;
    logic signed [PROD_BITS-1:0]    b_cprod_reg, b_cprod_next;
    logic signed [PROD_BITS-1:0]    b_pprod_reg [TAP_PAIRS];
    logic signed [PROD_BITS-1:0]    b_pprod_next [TAP_PAIRS];
    logic signed [SAMPLE_BITS-1:0]  b_centre_reg;
    logic                           b_pass_reg;
    logic                           b_end_reg;

    // output register
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0]  out_sample_reg, out_sample_next;
    logic                           record_end_reg;

    // ------------------------------------------------------------------
    // flow control: each stage loads when it is empty or its item moves on
    // ------------------------------------------------------------------
    logic out_free, b_free, a_free, issue, accept;

    assign out_free = !out_valid_reg || out_ready;
    assign b_free   = !b_valid_reg || out_free;
    assign a_free   = !a_valid_reg || b_free;
    assign issue    = (pend_reg != '0) && a_free;
    // the last pending result of the previous item may issue in the same cycle
    assign in_ready = (pend_reg == '0) || ((pend_reg == hbd_pkg::pend_t'(1)) && a_free);
    assign accept   = in_valid && in_ready;

    // ------------------------------------------------------------------
    // record bookkeeping for an accepted item
    // ------------------------------------------------------------------
    logic [COUNT_BITS-1:0] len_raw, len_eff, total, remain;
    logic                  last, due;
    hbd_pkg::pend_t        burst, cnt;

    always_comb
    begin
        len_raw = COUNT_BITS'(record_length_reg);
        // a zero length acts as length one: every sample closes an empty record
        len_eff = (len_raw == '0) ? COUNT_BITS'(1) : len_raw;
        total   = len_eff >> 1;
        last    = in_cnt_reg >= (len_eff - COUNT_BITS'(1));
        due     = (out_cnt_reg < total)
                  && ({2'b00, in_cnt_reg} >= ({1'b0, out_cnt_reg, 1'b0} + CW2'(LAG)));
        remain  = total - out_cnt_reg;
        burst   = (remain > COUNT_BITS'(hbd_pkg::MAX_RESULTS))
                  ? hbd_pkg::pend_t'(hbd_pkg::MAX_RESULTS)
                  : remain[hbd_pkg::PEND_BITS-1:0];

        if (last)
            cnt = (out_cnt_reg < total) ? burst : '0;
        else
            cnt = due ? hbd_pkg::pend_t'(1) : '0;

        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        if (accept)
        begin
            in_cnt_next  = last ? '0 : in_cnt_reg + COUNT_BITS'(1);
            out_cnt_next = last ? '0 : out_cnt_reg + COUNT_BITS'(cnt);
        end

        pend_next  = pend_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        total_next = total_reg;
        last_next  = last_reg;
        if (accept)
        begin
            pend_next  = cnt;
            idx_next   = out_cnt_reg;
            n_next     = in_cnt_reg;
            total_next = total;
            last_next  = last;
        end
        else if (issue)
        begin
            pend_next = pend_reg - hbd_pkg::pend_t'(1);
            idx_next  = idx_reg + COUNT_BITS'(1);
        end
    end

    // ------------------------------------------------------------------
    // issue: pick the taps of one result from the delay line
    // ------------------------------------------------------------------
    logic signed [CW-1:0]       c_full;
    logic signed [OFF_BITS-1:0] c_clip;

    always_comb
    begin
        c_full = $signed({3'b000, n_reg}) - $signed({2'b00, idx_reg, 1'b0});
        // beyond these bounds every tap already sits at an end of the line
        if (c_full < CW'(C_LO))
            c_clip = OFF_BITS'(C_LO);
        else if (c_full > CW'(C_HI))
            c_clip = OFF_BITS'(C_HI);
        else
            c_clip = OFF_BITS'(c_full);

        a_centre_next = dl_reg[tap_index(c_clip)];
        for (int k = 0; k < TAP_PAIRS; k++)
        begin
            a_psum_next[k] = PSUM_BITS'(dl_reg[tap_index(c_clip - OFF_BITS'(2 * k + 1))])
                           + PSUM_BITS'(dl_reg[tap_index(c_clip + OFF_BITS'(2 * k + 1))]);
        end
        a_pass_next = (idx_reg < COUNT_BITS'(TAP_PAIRS))
                      || (({1'b0, idx_reg} + (COUNT_BITS + 1)'(TAP_PAIRS)) >= {1'b0, total_reg});
        a_end_next  = last_reg && (pend_reg == hbd_pkg::pend_t'(1));
        a_valid_next = a_free ? issue : a_valid_reg;
    end

    // ------------------------------------------------------------------
    // constant multiplies
    // ------------------------------------------------------------------
    always_comb
    begin
        b_cprod_next = PROD_BITS'(a_centre_reg) * PROD_BITS'(hbd_pkg::CENTRE_COEF);
        for (int k = 0; k < TAP_PAIRS; k++)
        begin
            b_pprod_next[k] = PROD_BITS'(a_psum_reg[k]) * PROD_BITS'(hbd_pkg::PAIR_COEF[k]);
        end
        b_valid_next = b_free ? a_valid_reg : b_valid_reg;
    end

    // ------------------------------------------------------------------
    // tap sum, round half up, saturate
    // ------------------------------------------------------------------
    logic signed [ACC_BITS-1:0] acc, acc_rnd;
    logic signed [Q_BITS-1:0]   q;
    logic signed [SAMPLE_BITS-1:0] filt;

    always_comb
    begin
        acc = ACC_BITS'(b_cprod_reg);
        for (int k = 0; k < TAP_PAIRS; k++)
        begin
            acc = acc + ACC_BITS'(b_pprod_reg[k]);
        end
        acc_rnd = acc + ACC_BITS'(hbd_pkg::ROUND_BIAS);
        q       = $signed(acc_rnd[ACC_BITS-1:FRAC_BITS]);
        if (q > Q_BITS'(SMAX))
            filt = SMAX;
        else if (q < Q_BITS'(SMIN))
            filt = SMIN;
        else
            filt = SAMPLE_BITS'(q);

        out_sample_next = b_pass_reg ? b_centre_reg : filt;
        out_valid_next  = out_free ? b_valid_reg : out_valid_reg;
    end

    // ------------------------------------------------------------------
    // control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_length_reg <= hbd_pkg::RECORD_LENGTH_RESET;
            for (int k = 0; k < DEPTH; k++)
            begin
                dl_reg[k] <= '0;
            end
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            pend_reg      <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                record_length_reg <= cfg_wdata;
            if (accept)
            begin
                dl_reg[0] <= sample;
                for (int k = 1; k < DEPTH; k++)
                begin
                    dl_reg[k] <= dl_reg[k-1];
                end
            end
            in_cnt_reg    <= in_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            pend_reg      <= pend_next;
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        n_reg     <= n_next;
        total_reg <= total_next;
        last_reg  <= last_next;
        if (issue)
        begin
            a_centre_reg <= a_centre_next;
            a_psum_reg   <= a_psum_next;
            a_pass_reg   <= a_pass_next;
            a_end_reg    <= a_end_next;
        end
        if (b_free && a_valid_reg)
        begin
            b_cprod_reg  <= b_cprod_next;
            b_pprod_reg  <= b_pprod_next;
            b_centre_reg <= a_centre_reg;
            b_pass_reg   <= a_pass_reg;
            b_end_reg    <= a_end_reg;
        end
        if (out_free && b_valid_reg)
        begin
            out_sample_reg <= out_sample_next;
            record_end_reg <= b_end_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign record_end = record_end_reg;

endmodule

/* hw/rtl/hbd_checker.sv */
module hbd_checker #(
    parameter int SAMPLE_BITS = hbd_pkg::SAMPLE_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic signed [SAMPLE_BITS-1:0] sample,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] out_sample,
    input logic                          record_end
);

    // a waiting input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(sample))
        else $error("input item changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(record_end))
        else $error("result changed while stalled");

    // reset leaves nothing to deliver and the input open
    a_reset: assert property (@(posedge clk) !rst_n |-> !out_valid && in_ready)
        else $error("reset state wrong");

    // with no new item and the output always taken, a full burst of results drains
    // and the input opens again
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ready && !in_valid) ##1 (out_ready && !in_valid) ##1 (out_ready && !in_valid)
        ##1 (out_ready && !in_valid) ##1 (out_ready && !in_valid) ##1 out_ready
        |-> in_ready)
        else $error("input held after burst drained");

endmodule

bind half_band_decimator_top hbd_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_hbd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .record_end (record_end)
);
